>>> src/frqg_pkg.sv
package frqg_pkg;

    localparam int DEPTH_DEF = 512;
    localparam logic [31:0] WINDOW_MS = 32'd5000;

    localparam int NOW_W   = 32;
    localparam int LVL_W   = 3;
    localparam int FC_W    = 10;
    localparam int EFF_W   = 5;
    localparam int CRE_W   = 5;
    localparam int ITM_W   = 5;
    localparam int TXT_W   = 10;
    localparam int MAP_W   = 7;
    localparam int FORE_W  = 6;
    localparam int FPS_W   = 10;
    localparam int FRC_W   = 4;
    localparam int OUT_W   = 56;

    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register indexes, decoded from paddr[2]
    localparam logic REG_FORCED = 1'b0;
    localparam logic REG_MAXFPS = 1'b1;

    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    localparam logic [LVL_W-1:0] LVL_MAX = 3'd4;

    typedef struct packed {
        logic capture;
        logic push;
        logic refresh;
        logic rd_issue;
        logic pop;
        logic apply_forced;
        logic adapt_start;
        logic adapt_inc;
        logic adapt_dec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_refresh;
        logic many_held;
        logic pop_due;
        logic forced;
        logic update_due;
        logic out_busy;
    } t_status;

    function automatic logic [EFF_W-1:0] tab_effects(input logic [LVL_W-1:0] lv);
        logic [EFF_W-1:0] v;
        unique case (lv)
            3'd0:    v = 5'd20;
            3'd1:    v = 5'd10;
            3'd2:    v = 5'd7;
            3'd3:    v = 5'd4;
            default: v = 5'd2;
        endcase
        return v;
    endfunction

    function automatic logic [CRE_W-1:0] tab_creatures(input logic [LVL_W-1:0] lv);
        logic [CRE_W-1:0] v;
        unique case (lv)
            3'd0:    v = 5'd20;
            3'd1:    v = 5'd10;
            3'd2:    v = 5'd7;
            3'd3:    v = 5'd5;
            default: v = 5'd3;
        endcase
        return v;
    endfunction

    function automatic logic [TXT_W-1:0] tab_texts(input logic [LVL_W-1:0] lv);
        logic [TXT_W-1:0] v;
        unique case (lv)
            3'd0:    v = 10'd1000;
            3'd1:    v = 10'd50;
            3'd2:    v = 10'd30;
            3'd3:    v = 10'd15;
            default: v = 10'd5;
        endcase
        return v;
    endfunction

    function automatic logic [MAP_W-1:0] tab_map(input logic [LVL_W-1:0] lv);
        logic [MAP_W-1:0] v;
        unique case (lv)
            3'd0:    v = 7'd0;
            3'd1:    v = 7'd10;
            3'd2:    v = 7'd20;
            3'd3:    v = 7'd50;
            default: v = 7'd100;
        endcase
        return v;
    endfunction

    function automatic logic [FORE_W-1:0] tab_fore(input logic [LVL_W-1:0] lv);
        logic [FORE_W-1:0] v;
        unique case (lv)
            3'd0:    v = 6'd0;
            3'd1:    v = 6'd20;
            3'd2:    v = 6'd40;
            3'd3:    v = 6'd50;
            default: v = 6'd60;
        endcase
        return v;
    endfunction

endpackage

>>> src/frqg_cfg.sv
module frqg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frqg_pkg::APB_AW-1:0] paddr,
    input  logic [frqg_pkg::APB_DW-1:0] pwdata,
    output logic [frqg_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [frqg_pkg::FRC_W-1:0]  o_forced_level,
    output logic [frqg_pkg::FPS_W-1:0]  o_max_fps
);
    import frqg_pkg::*;

    logic [FRC_W-1:0] r_forced;
    logic [FPS_W-1:0] r_max_fps;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forced  <= 4'hF;
            r_max_fps <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_FORCED) begin
                r_forced <= pwdata[FRC_W-1:0];
            end else begin
                r_max_fps <= pwdata[FPS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FORCED) begin
            prdata = {{(APB_DW-FRC_W){1'b0}}, r_forced};
        end else begin
            prdata = {{(APB_DW-FPS_W){1'b0}}, r_max_fps};
        end
    end

    assign o_forced_level = r_forced;
    assign o_max_fps      = r_max_fps;
endmodule

>>> src/frqg_ctrl.sv
module frqg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  frqg_pkg::t_status i_status,
    output frqg_pkg::t_cmd    o_cmd
);
    import frqg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_RDREQ = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_LEVEL = 3'd4;
    localparam logic [2:0] S_INC   = 3'd5;
    localparam logic [2:0] S_DEC   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.is_refresh) begin
                    o_cmd.refresh = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state = S_RDREQ;
                end
            end
            S_RDREQ: begin
                // the newest entry always stays
                if (i_status.many_held) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_LEVEL;
                end
            end
            S_CHECK: begin
                if (i_status.pop_due) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_RDREQ;
                end else begin
                    n_state = S_LEVEL;
                end
            end
            S_LEVEL: begin
                if (i_status.forced) begin
                    o_cmd.apply_forced = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.update_due) begin
                    o_cmd.adapt_start = 1'b1;
                    n_state = S_INC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INC: begin
                o_cmd.adapt_inc = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.adapt_dec = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> src/frqg_dpath.sv
module frqg_dpath #(
    parameter int DEPTH = frqg_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frqg_pkg::t_cmd              i_cmd,
    output frqg_pkg::t_status           o_status,
    input  logic                        i_op,
    input  logic [frqg_pkg::NOW_W-1:0]  i_now,
    input  logic [frqg_pkg::FRC_W-1:0]  i_forced_level,
    input  logic [frqg_pkg::FPS_W-1:0]  i_max_fps,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [frqg_pkg::OUT_W-1:0]  o_out_data
);
    import frqg_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int NT_W   = CNT_W + 4;
    localparam int THR_W  = 13;
    localparam int CMP_W  = (NT_W > THR_W) ? NT_W : THR_W;

    logic [NOW_W-1:0]  r_mem [DEPTH];
    logic [NOW_W-1:0]  r_rd;
    logic              r_op;
    logic [NOW_W-1:0]  r_now;
    logic [ADDR_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_count;
    logic [LVL_W-1:0]  r_level;
    logic [NOW_W-1:0]  r_last;
    logic [LVL_W-1:0]  r_s;
    logic [6:0]        r_f;
    logic              r_ov;
    logic [LVL_W-1:0]  r_out_lv;
    logic [FC_W-1:0]   r_out_cnt;

    logic              full;
    logic [ADDR_W-1:0] oldest_inc;
    logic [CNT_W:0]    wsum;
    logic [ADDR_W-1:0] waddr;
    logic [NOW_W-1:0]  pop_diff;
    logic [NOW_W-1:0]  upd_diff;
    logic [LVL_W-1:0]  s0;
    logic [6:0]        f0;
    logic [5:0]        fac_up;
    logic [5:0]        fac_dn;
    logic [THR_W-1:0]  thr_up;
    logic [THR_W-1:0]  thr_dn;
    logic [NT_W-1:0]   n10;
    logic [LVL_W-1:0]  lv_out;

    assign full       = (r_count == CNT_W'(DEPTH));
    assign oldest_inc = (r_oldest == ADDR_W'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
    assign wsum       = (CNT_W + 1)'(r_oldest) + (CNT_W + 1)'(r_count);
    assign waddr      = (wsum >= (CNT_W + 1)'(DEPTH)) ?
                        ADDR_W'(wsum - (CNT_W + 1)'(DEPTH)) : ADDR_W'(wsum);

    // signed difference tests for "strictly later"
    assign pop_diff = r_now - (r_rd + WINDOW_MS);
    assign upd_diff = (r_last + WINDOW_MS) - r_now;

    // level seed and clamped target rate for the re-evaluation
    always_comb begin
        s0 = r_level;
        if (s0 < 3'd1) begin
            s0 = 3'd1;
        end
        if (s0 > LVL_MAX) begin
            s0 = LVL_MAX;
        end
        if (i_max_fps < 10'd10 || i_max_fps > 10'd100) begin
            f0 = 7'd100;
        end else begin
            f0 = i_max_fps[6:0];
        end
        if (s0 >= 3'd2 && f0 > 7'd60) begin
            f0 = 7'd60;
        end
    end

    assign fac_up = 6'd40 - (({3'b000, r_s} << 1) + {3'b000, r_s});
    assign fac_dn = 6'd45 - {3'b000, r_s};
    assign thr_up = THR_W'(r_f) * THR_W'(fac_up);
    assign thr_dn = THR_W'(r_f) * THR_W'(fac_dn);
    assign n10    = (NT_W'(r_count) << 3) + (NT_W'(r_count) << 1);

    always_comb begin
        o_status.is_refresh = (r_op == OP_REFRESH);
        o_status.many_held  = (r_count > CNT_W'(1));
        o_status.pop_due    = (pop_diff != '0) && !pop_diff[NOW_W-1];
        o_status.forced     = (i_forced_level <= FRC_W'(LVL_MAX));
        o_status.update_due = !((upd_diff != '0) && !upd_diff[NOW_W-1]);
        o_status.out_busy   = r_ov && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[full ? r_oldest : waddr] <= r_now;
        end
        if (i_cmd.rd_issue) begin
            r_rd <= r_mem[r_oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_now <= i_now;
        end
        if (i_cmd.adapt_start) begin
            r_s <= s0;
            r_f <= f0;
        end
        if (i_cmd.adapt_inc) begin
            if (CMP_W'(n10) < CMP_W'(thr_up) && r_s != LVL_MAX) begin
                r_s <= r_s + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_lv  <= lv_out;
            r_out_cnt <= FC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_level  <= '0;
            r_last   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.refresh) begin
                r_last <= r_now;
            end
            if (i_cmd.push) begin
                if (full) begin
                    r_oldest <= oldest_inc;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.pop) begin
                r_oldest <= oldest_inc;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.apply_forced) begin
                r_level <= i_forced_level[LVL_W-1:0];
            end
            if (i_cmd.adapt_start) begin
                r_last <= r_now;
            end
            if (i_cmd.adapt_dec) begin
                if (CMP_W'(n10) > CMP_W'(thr_dn) && r_s > 3'd1) begin
                    r_level <= r_s - 1'b1;
                end else begin
                    r_level <= r_s;
                end
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign lv_out = (r_level > LVL_MAX) ? LVL_MAX : r_level;

    assign o_out_valid = r_ov;
    assign o_out_data  = {
        4'b0000,
        tab_fore(r_out_lv),
        tab_map(r_out_lv),
        tab_texts(r_out_lv),
        tab_creatures(r_out_lv),
        tab_creatures(r_out_lv),
        tab_effects(r_out_lv),
        r_out_cnt,
        (r_out_lv <= 3'd2),
        r_out_lv
    };
endmodule

>>> src/frame_rate_quality_governor_core.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: now_ms; tuser: opcode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: level and render limits
// apb       in   psel, penable, pwrite, pready  forced_level @0, max_fps @4
//
// one event at a time: a refresh beat passes the push and done states before the next accept;
// a frame beat reads the oldest frame time in the ring and reads it again after each window
// entry dropped, then passes the level states; done waits while the output register is held
// synchronous active-low reset; the ring holds no reset value and needs no clearing
// a finished result waits in the output register, and the next beat is accepted meanwhile
module frame_rate_quality_governor_core #(
    parameter int WINDOW_DEPTH = frqg_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] now_ms
    input  logic [frqg_pkg::NOW_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] level, [3] allow_fading, [13:4] frame_count, [18:14] effects_limit,
    // [23:19] creatures_limit, [28:24] items_limit, [38:29] texts_limit,
    // [45:39] map_interval_ms, [51:46] foreground_interval_ms, [55:52] zero
    output logic [frqg_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frqg_pkg::APB_AW-1:0] paddr,
    input  logic [frqg_pkg::APB_DW-1:0] pwdata,
    output logic [frqg_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import frqg_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [FRC_W-1:0] forced_level;
    logic [FPS_W-1:0] max_fps;

    frqg_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_forced_level (forced_level),
        .o_max_fps      (max_fps)
    );

    frqg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    frqg_dpath #(
        .DEPTH (WINDOW_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (s_axis_tuser[0]),
        .i_now          (s_axis_tdata),
        .i_forced_level (forced_level),
        .i_max_fps      (max_fps),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata)
    );
endmodule

>>> dv/frame_rate_quality_governor_core_tb.sv
module frame_rate_quality_governor_core_tb;
    import frqg_pkg::*;

    localparam int RING_DEPTH    = DEPTH_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 16;
    localparam int FLOOD_EVENTS  = 530;
    localparam int PHASE_EVENTS  = 47;

    typedef struct packed {
        logic        op;
        logic [31:0] now;
    } t_event;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic              fading;
        logic [FC_W-1:0]   frames;
        logic [EFF_W-1:0]  effects;
        logic [CRE_W-1:0]  creatures;
        logic [ITM_W-1:0]  items;
        logic [TXT_W-1:0]  texts;
        logic [MAP_W-1:0]  map_ms;
        logic [FORE_W-1:0] fore_ms;
    } t_limits;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [NOW_W-1:0]    s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    frame_rate_quality_governor_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    logic [EFF_W-1:0]  effects_by_level   [5] = '{5'd20, 5'd10, 5'd7, 5'd4, 5'd2};
    logic [CRE_W-1:0]  creatures_by_level [5] = '{5'd20, 5'd10, 5'd7, 5'd5, 5'd3};
    logic [ITM_W-1:0]  items_by_level     [5] = '{5'd20, 5'd10, 5'd7, 5'd5, 5'd3};
    logic [TXT_W-1:0]  texts_by_level     [5] = '{10'd1000, 10'd50, 10'd30, 10'd15, 10'd5};
    logic [MAP_W-1:0]  map_by_level       [5] = '{7'd0, 7'd10, 7'd20, 7'd50, 7'd100};
    logic [FORE_W-1:0] fore_by_level      [5] = '{6'd0, 6'd20, 6'd40, 6'd50, 6'd60};

    // governor state mirrored here
    logic [31:0] win_times [RING_DEPTH];
    int unsigned win_head = 0;
    int unsigned win_held = 0;
    logic [2:0]  gov_level = '0;
    logic [31:0] gov_stamp = '0;
    logic [3:0]  cfg_forced = 4'hF;
    logic [9:0]  cfg_fps = '0;

    t_event  pending_events [$];
    t_limits expected_limits [$];
    t_event  in_flight;
    int      src_wait = 0;
    int      sink_wait = 0;
    bit      idle_src = 1'b0;
    bit      stall_sink = 1'b0;
    int      mismatches = 0;
    logic [31:0] event_clock = '0;

    // a strictly later than b, modulo 2^32
    function automatic bit after_ms(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d != 0 && !d[31];
    endfunction

    function automatic t_limits govern(t_event ev);
        int unsigned fps;
        int unsigned s;
        int unsigned n10;
        int unsigned lv;
        t_limits     r;
        if (ev.op == OP_REFRESH) begin
            gov_stamp = ev.now;
        end else begin
            if (win_held >= RING_DEPTH) begin
                // ring full: newest overwrites oldest
                win_times[win_head] = ev.now;
                win_head = (win_head + 1) % RING_DEPTH;
            end else begin
                win_times[(win_head + win_held) % RING_DEPTH] = ev.now;
                win_held++;
            end
            while (win_held > 1 && after_ms(ev.now, win_times[win_head] + WINDOW_MS)) begin
                win_head = (win_head + 1) % RING_DEPTH;
                win_held--;
            end
            if (cfg_forced <= 4) begin
                gov_level = cfg_forced[2:0];
            end else if (!after_ms(gov_stamp + WINDOW_MS, ev.now)) begin
                gov_stamp = ev.now;
                s = gov_level;
                if (s < 1) s = 1;
                if (s > 4) s = 4;
                fps = cfg_fps;
                if (fps < 10) fps = 100;
                if (fps > 100) fps = 100;
                if (s >= 2 && fps > 60) fps = 60;
                // thresholds kept in tenths of a frame
                n10 = win_held * 10;
                if (n10 < fps * (40 - 3 * s) && s != 4) s++;
                if (n10 > fps * (45 - s) && s > 1) s--;
                gov_level = s[2:0];
            end
        end
        lv = (gov_level > 4) ? 4 : gov_level;
        r.level     = lv[2:0];
        r.fading    = (lv <= 2);
        r.frames    = win_held[FC_W-1:0];
        r.effects   = effects_by_level[lv];
        r.creatures = creatures_by_level[lv];
        r.items     = items_by_level[lv];
        r.texts     = texts_by_level[lv];
        r.map_ms    = map_by_level[lv];
        r.fore_ms   = fore_by_level[lv];
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // event driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_limits.insert(expected_limits.size(), govern(in_flight));
                src_wait = idle_src ? $urandom_range(0, 16) : 0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() > 0) begin
                    in_flight = pending_events[0];
                    pending_events.delete(0);
                    s_axis_tdata  <= in_flight.now;
                    s_axis_tuser  <= in_flight.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_limits want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_limits.size() == 0) begin
                    $error("result beat with no event outstanding");
                    mismatches++;
                end else begin
                    want = expected_limits[0];
                    expected_limits.delete(0);
                    check_field("level", want.level, m_axis_tdata[2:0]);
                    check_field("allow_fading", want.fading, m_axis_tdata[3]);
                    check_field("frame_count", want.frames, m_axis_tdata[13:4]);
                    check_field("effects_limit", want.effects, m_axis_tdata[18:14]);
                    check_field("creatures_limit", want.creatures, m_axis_tdata[23:19]);
                    check_field("items_limit", want.items, m_axis_tdata[28:24]);
                    check_field("texts_limit", want.texts, m_axis_tdata[38:29]);
                    check_field("map_interval_ms", want.map_ms, m_axis_tdata[45:39]);
                    check_field("foreground_interval_ms", want.fore_ms, m_axis_tdata[51:46]);
                end
                sink_wait = stall_sink ? $urandom_range(0, 16) : 0;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_governor(input logic [3:0] forced, input logic [9:0] fps);
        apb_write(REG_FORCED, {28'd0, forced});
        apb_write(REG_MAXFPS, {22'd0, fps});
        cfg_forced = forced;
        cfg_fps    = fps;
    endtask

    // hold off until every event has produced its beat and the block settles
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_events.size() != 0 || s_axis_tvalid || expected_limits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_event(input logic op, input logic [31:0] now);
        t_event ev;
        ev.op  = op;
        ev.now = now;
        pending_events.insert(pending_events.size(), ev);
        event_clock = now;
    endtask

    // bursts of frames at a chosen average spacing, window-edge steps and noise
    task automatic plan_random(input int count);
        int left;
        int seg;
        int mode;
        int spacing;
        logic op;
        left = count;
        while (left > 0) begin
            mode = $urandom_range(0, 9);
            seg  = $urandom_range(4, 24);
            if (seg > left) seg = left;
            case (mode)
                0:       spacing = 10;
                1:       spacing = 40;
                2, 3:    spacing = 110;
                4, 5:    spacing = 160;
                6:       spacing = 400;
                default: spacing = 1500;
            endcase
            repeat (seg) begin
                op = ($urandom_range(0, 11) == 0) ? OP_REFRESH : OP_FRAME;
                if (mode == 8)
                    add_event(op, event_clock + $urandom_range(4990, 5010));
                else if (mode == 9)
                    add_event(1'($urandom_range(0, 1)), $urandom());
                else
                    add_event(op, event_clock + $urandom_range(0, 2 * spacing));
            end
            left -= seg;
        end
    endtask

    initial begin : stimulus
        logic [3:0] forced_plan [PHASES];
        int         fps_plan    [PHASES];
        logic [9:0] fps;
        forced_plan = '{4'd15, 4'd0, 4'd5, 4'd4, 4'd8, 4'd9, 4'd2, 4'd10,
                        4'd11, 4'd3, 4'd12, 4'd13, 4'd1, 4'd6, 4'd14, 4'd7};
        fps_plan    = '{0, 1000, 10, 5, 30, 60, 9, 61,
                        100, 511, -1, 1000, -1, 101, 512, 20};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: timer boundaries, wraparound, equal stamps, all-ones time
        idle_src   = 1'b1;
        stall_sink = 1'b1;
        add_event(OP_FRAME,   32'd0);
        add_event(OP_REFRESH, 32'd3);
        add_event(OP_FRAME,   32'd5003);
        add_event(OP_FRAME,   32'd10003);
        add_event(OP_FRAME,   32'hFFFF_FFFF);
        add_event(OP_REFRESH, 32'hFFFF_FFFF);
        add_event(OP_FRAME,   32'd4999);
        add_event(OP_FRAME,   32'd10000);
        add_event(OP_FRAME,   32'd10000);
        add_event(OP_FRAME,   32'h8000_0000);
        add_event(OP_FRAME,   32'h8000_1388);
        add_event(OP_REFRESH, 32'h5555_5555);
        add_event(OP_FRAME,   32'hAAAA_AAAA);
        add_event(OP_FRAME,   32'hAAAA_AAAA);
        add_event(OP_FRAME,   32'hAAAA_BE33);
        add_event(OP_FRAME,   32'hFFFF_FFF0);
        add_event(OP_FRAME,   32'h0000_0010);
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++) begin
            fps = (fps_plan[ph] < 0) ? 10'($urandom_range(0, 1000)) : 10'(fps_plan[ph]);
            set_governor(forced_plan[ph], fps);
            idle_src   = ($urandom_range(0, 3) != 0);
            stall_sink = ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                // dense burst overruns the ring within one window
                repeat (FLOOD_EVENTS)
                    add_event(($urandom_range(0, 39) == 0) ? OP_REFRESH : OP_FRAME,
                              event_clock + $urandom_range(0, 9));
            end else begin
                plan_random(PHASE_EVENTS);
            end
            wait_quiet();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> frame_rate_quality_governor_core.f
src/frqg_pkg.sv
src/frqg_cfg.sv
src/frqg_ctrl.sv
src/frqg_dpath.sv
src/frame_rate_quality_governor_core.sv
dv/frame_rate_quality_governor_core_tb.sv
